>>> rtl/hrdl_pkg.sv
`default_nettype none
// ============================================================================
// hrdl_pkg : shared types, constants and microcode for the hash ring lookup
// Field widths, FNV-1a constants, control word layout and the step program.
// ============================================================================
package hrdl_pkg;

    // field widths
    localparam int HASH_W     = 64;
    localparam int ID_W       = 64;
    localparam int SLOT_W     = 11;
    localparam int DISK_W     = 4;
    localparam int CNT_W      = 12;
    localparam int BYTES      = 8;
    localparam int BYTE_IDX_W = 3;

    // defaults for the top-level parameters
    localparam int MAX_POINTS_DEF = 2048;
    localparam int MAX_DISKS_DEF  = 16;

    // 64-bit fnv-1a: prime = 2^40 + 0x1b3
    localparam logic [HASH_W-1:0] FNV_BASIS      = 64'hcbf2_9ce4_8422_2325;
    localparam logic [8:0]        FNV_PRIME_LO   = 9'h1b3;
    localparam int                FNV_PRIME_SHIFT = 40;

    // opcodes
    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    // microcode step numbers
    localparam int STEP_W = 4;
    localparam logic [STEP_W-1:0] S_IDLE     = 4'd0;
    localparam logic [STEP_W-1:0] S_DISPATCH = 4'd1;
    localparam logic [STEP_W-1:0] S_LOAD     = 4'd2;
    localparam logic [STEP_W-1:0] S_HASH     = 4'd3;
    localparam logic [STEP_W-1:0] S_RD_LAST  = 4'd4;
    localparam logic [STEP_W-1:0] S_CHK_LAST = 4'd5;
    localparam logic [STEP_W-1:0] S_CHK_FST  = 4'd6;
    localparam logic [STEP_W-1:0] S_LOOP     = 4'd7;
    localparam logic [STEP_W-1:0] S_UPDATE   = 4'd8;
    localparam logic [STEP_W-1:0] S_FINAL    = 4'd9;
    localparam logic [STEP_W-1:0] S_EMIT     = 4'd10;
    localparam logic [STEP_W-1:0] S_WRAP     = 4'd11;
    localparam logic [STEP_W-1:0] S_LAST     = 4'd11;

    // memory read address select
    typedef enum logic [2:0] {
        RD_NONE = 3'd0,
        RD_LAST = 3'd1,
        RD_ZERO = 3'd2,
        RD_MID  = 3'd3,
        RD_HI   = 3'd4
    } t_rd;

    // jump conditions
    typedef enum logic [2:0] {
        C_NEXT      = 3'd0,
        C_ALWAYS    = 3'd1,
        C_NO_START  = 3'd2,
        C_LOOKUP    = 3'd3,
        C_HASH_MORE = 3'd4,
        C_ABOVE     = 3'd5,
        C_ATMOST    = 3'd6,
        C_SPAN_DONE = 3'd7
    } t_cond;

    // control word
    typedef struct packed {
        logic              idle;
        logic              wr;
        logic              hash;
        logic              setup;
        logic              upd;
        logic              wrap;
        logic              emit;
        t_rd               rd;
        t_cond             cond;
        logic [STEP_W-1:0] target;
    } t_ctrl;

    // datapath status for the jump conditions
    typedef struct packed {
        logic lookup;
        logic hash_more;
        logic above;
        logic atmost;
        logic span_done;
    } t_stat;

    // the step program
    function automatic t_ctrl ucode(input logic [STEP_W-1:0] step);
        t_ctrl c;
        c = '{idle: 1'b0, wr: 1'b0, hash: 1'b0, setup: 1'b0, upd: 1'b0,
              wrap: 1'b0, emit: 1'b0, rd: RD_NONE, cond: C_NEXT, target: S_IDLE};
        unique case (step)
            S_IDLE: begin
                c.idle   = 1'b1;
                c.cond   = C_NO_START;
                c.target = S_IDLE;
            end
            S_DISPATCH: begin
                c.cond   = C_LOOKUP;
                c.target = S_HASH;
            end
            S_LOAD: begin
                c.wr     = 1'b1;
                c.cond   = C_ALWAYS;
                c.target = S_IDLE;
            end
            S_HASH: begin
                c.hash   = 1'b1;
                c.cond   = C_HASH_MORE;
                c.target = S_HASH;
            end
            S_RD_LAST: begin
                c.setup = 1'b1;
                c.rd    = RD_LAST;
            end
            S_CHK_LAST: begin
                c.rd     = RD_ZERO;
                c.cond   = C_ABOVE;
                c.target = S_WRAP;
            end
            S_CHK_FST: begin
                c.cond   = C_ATMOST;
                c.target = S_WRAP;
            end
            S_LOOP: begin
                c.rd     = RD_MID;
                c.cond   = C_SPAN_DONE;
                c.target = S_FINAL;
            end
            S_UPDATE: begin
                c.upd    = 1'b1;
                c.cond   = C_ALWAYS;
                c.target = S_LOOP;
            end
            S_FINAL: begin
                c.rd = RD_HI;
            end
            S_EMIT: begin
                c.emit   = 1'b1;
                c.cond   = C_ALWAYS;
                c.target = S_IDLE;
            end
            S_WRAP: begin
                c.wrap   = 1'b1;
                c.cond   = C_ALWAYS;
                c.target = S_FINAL;
            end
            default: begin
                c.cond   = C_ALWAYS;
                c.target = S_IDLE;
            end
        endcase
        return c;
    endfunction

endpackage
`default_nettype wire

>>> rtl/hash_ring_disk_lookup.sv
`default_nettype none
// ============================================================================
// hash_ring_disk_lookup : consistent hash ring lookup with 64-bit fnv-1a
// Loads sorted ring points and maps object ids to disks by binary search.
// ============================================================================
// sequence: load runs dispatch and the ring write; lookup runs dispatch, the fnv
//   rounds, bound setup, end checks, k search halvings (up to 11 at 2048 points),
//   final read and emit; a hash above the last or at most the first point wraps
// throughput: one item at a time, the next start taken in the strobe cycle;
//   rate set by the eight fnv rounds and the single ring read port
// reset: idle, point count 1, no strobe, ring not cleared; o_done cannot be stalled
module hash_ring_disk_lookup #(
    parameter int MAX_POINTS = hrdl_pkg::MAX_POINTS_DEF,
    parameter int MAX_DISKS  = hrdl_pkg::MAX_DISKS_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic                        i_opcode,
    input  wire logic [hrdl_pkg::SLOT_W-1:0] i_slot,
    input  wire logic [hrdl_pkg::HASH_W-1:0] i_point_hash,
    input  wire logic [hrdl_pkg::DISK_W-1:0] i_point_disk,
    input  wire logic [hrdl_pkg::ID_W-1:0]   i_object_id,
    input  wire logic                        i_cfg_we,
    input  wire logic [hrdl_pkg::CNT_W-1:0]  i_cfg_wdata,
    output logic                             o_done,
    output logic [hrdl_pkg::DISK_W-1:0]      o_disk_index,
    output logic [hrdl_pkg::SLOT_W-1:0]      o_found_slot
);

    hrdl_pkg::t_ctrl w_ctrl;
    hrdl_pkg::t_stat w_stat;
    logic            w_accept;

    // sequencer
    hrdl_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_stat   (w_stat),
        .o_ctrl   (w_ctrl),
        .o_accept (w_accept),
        .busy     (busy)
    );

    // datapath
    hrdl_dp #(
        .MAX_POINTS (MAX_POINTS),
        .MAX_DISKS  (MAX_DISKS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctrl       (w_ctrl),
        .i_accept     (w_accept),
        .i_opcode     (i_opcode),
        .i_slot       (i_slot),
        .i_point_hash (i_point_hash),
        .i_point_disk (i_point_disk),
        .i_object_id  (i_object_id),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_stat       (w_stat),
        .o_done       (o_done),
        .o_disk_index (o_disk_index),
        .o_found_slot (o_found_slot)
    );

endmodule
`default_nettype wire

>>> rtl/hrdl_seq.sv
`default_nettype none
// ============================================================================
// hrdl_seq : microcode sequencer
// Step counter over the control program with conditional jumps.
// ============================================================================
module hrdl_seq (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            start,
    input  wire hrdl_pkg::t_stat i_stat,
    output hrdl_pkg::t_ctrl      o_ctrl,
    output logic                 o_accept,
    output logic                 busy
);

    logic [hrdl_pkg::STEP_W-1:0] r_step;
    logic [hrdl_pkg::STEP_W-1:0] n_step;
    hrdl_pkg::t_ctrl             w_ctrl;
    logic                        w_take;

    // control word fetch
    always_comb begin
        w_ctrl = hrdl_pkg::ucode(r_step);
    end

    // jump condition select
    always_comb begin
        unique case (w_ctrl.cond)
            hrdl_pkg::C_NEXT:      w_take = 1'b0;
            hrdl_pkg::C_ALWAYS:    w_take = 1'b1;
            hrdl_pkg::C_NO_START:  w_take = !start;
            hrdl_pkg::C_LOOKUP:    w_take = i_stat.lookup;
            hrdl_pkg::C_HASH_MORE: w_take = i_stat.hash_more;
            hrdl_pkg::C_ABOVE:     w_take = i_stat.above;
            hrdl_pkg::C_ATMOST:    w_take = i_stat.atmost;
            hrdl_pkg::C_SPAN_DONE: w_take = i_stat.span_done;
            default:               w_take = 1'b1;
        endcase
        n_step = w_take ? w_ctrl.target : r_step + 1'b1;
    end

    // step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= hrdl_pkg::S_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

    assign o_ctrl   = w_ctrl;
    assign busy     = !w_ctrl.idle;
    assign o_accept = w_ctrl.idle && start;

    // checks
    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_step <= hrdl_pkg::S_LAST)
        else $error("step counter outside program");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_accept |=> (busy && r_step == hrdl_pkg::S_DISPATCH))
        else $error("accepted item did not start the program");

endmodule
`default_nettype wire

>>> rtl/hrdl_dp.sv
`default_nettype none
// ============================================================================
// hrdl_dp : datapath of the hash ring lookup
// Ring memory, fnv-1a round unit, search bounds and result registers.
// ============================================================================
module hrdl_dp #(
    parameter int MAX_POINTS = hrdl_pkg::MAX_POINTS_DEF,
    parameter int MAX_DISKS  = hrdl_pkg::MAX_DISKS_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire hrdl_pkg::t_ctrl             i_ctrl,
    input  wire logic                        i_accept,
    input  wire logic                        i_opcode,
    input  wire logic [hrdl_pkg::SLOT_W-1:0] i_slot,
    input  wire logic [hrdl_pkg::HASH_W-1:0] i_point_hash,
    input  wire logic [hrdl_pkg::DISK_W-1:0] i_point_disk,
    input  wire logic [hrdl_pkg::ID_W-1:0]   i_object_id,
    input  wire logic                        i_cfg_we,
    input  wire logic [hrdl_pkg::CNT_W-1:0]  i_cfg_wdata,
    output hrdl_pkg::t_stat                  o_stat,
    output logic                             o_done,
    output logic [hrdl_pkg::DISK_W-1:0]      o_disk_index,
    output logic [hrdl_pkg::SLOT_W-1:0]      o_found_slot
);

    localparam int AW = $clog2(MAX_POINTS);

    // ring memory
    logic [hrdl_pkg::HASH_W-1:0] r_ring_hash [MAX_POINTS];
    logic [hrdl_pkg::DISK_W-1:0] r_ring_disk [MAX_POINTS];
    logic [hrdl_pkg::HASH_W-1:0] r_q_hash;
    logic [hrdl_pkg::DISK_W-1:0] r_q_disk;

    // captured item
    logic                            r_op;
    logic [hrdl_pkg::SLOT_W-1:0]     r_slot;
    logic [hrdl_pkg::HASH_W-1:0]     r_pt_hash;
    logic [hrdl_pkg::DISK_W-1:0]     r_pt_disk;
    logic [hrdl_pkg::ID_W-1:0]       r_id;
    logic [hrdl_pkg::HASH_W-1:0]     r_hash;
    logic [hrdl_pkg::BYTE_IDX_W-1:0] r_byte;

    // search bounds and config
    logic [AW-1:0]                r_lo;
    logic [AW-1:0]                r_hi;
    logic [hrdl_pkg::CNT_W-1:0]   r_points;

    // result
    logic                         r_done;
    logic [hrdl_pkg::DISK_W-1:0]  r_disk;
    logic [hrdl_pkg::SLOT_W-1:0]  r_found;

    logic [31:0]                  w_count;
    logic [AW-1:0]                w_last;
    logic [AW-1:0]                w_span;
    logic [AW-1:0]                w_mid;
    logic [AW-1:0]                w_raddr;
    logic [AW-1:0]                w_waddr;
    logic                         w_rd_en;
    logic                         w_slot_ok;
    logic [hrdl_pkg::DISK_W-1:0]  w_disk_clamp;
    logic [hrdl_pkg::HASH_W-1:0]  w_mix;
    logic [hrdl_pkg::HASH_W-1:0]  w_prod;
    logic [hrdl_pkg::HASH_W-1:0]  w_round;

    // active point count, clamped to 1..MAX_POINTS
    always_comb begin
        if (r_points == '0) begin
            w_count = 32'd1;
        end else if (32'(r_points) > 32'(MAX_POINTS)) begin
            w_count = 32'(MAX_POINTS);
        end else begin
            w_count = 32'(r_points);
        end
        w_last = AW'(w_count - 32'd1);
    end

    // binary search midpoint
    assign w_span = r_hi - r_lo;
    assign w_mid  = r_lo + (w_span >> 1);

    // read address select
    always_comb begin
        unique case (i_ctrl.rd)
            hrdl_pkg::RD_LAST: w_raddr = w_last;
            hrdl_pkg::RD_ZERO: w_raddr = '0;
            hrdl_pkg::RD_MID:  w_raddr = w_mid;
            hrdl_pkg::RD_HI:   w_raddr = r_hi;
            default:           w_raddr = '0;
        endcase
    end
    assign w_rd_en   = (i_ctrl.rd != hrdl_pkg::RD_NONE);
    assign w_slot_ok = (32'(r_slot) < 32'(MAX_POINTS));
    assign w_waddr   = AW'(r_slot);

    // ring memory, registered read
    always_ff @(posedge i_clk) begin
        if (i_ctrl.wr && w_slot_ok) begin
            r_ring_hash[w_waddr] <= r_pt_hash;
            r_ring_disk[w_waddr] <= r_pt_disk;
        end
        if (w_rd_en) begin
            r_q_hash <= r_ring_hash[w_raddr];
            r_q_disk <= r_ring_disk[w_raddr];
        end
    end

    // disk index clamp on capture
    assign w_disk_clamp = (32'(i_point_disk) >= 32'(MAX_DISKS))
                        ? hrdl_pkg::DISK_W'(MAX_DISKS - 1) : i_point_disk;

    // one fnv-1a round: xor low byte, multiply by 2^40 + 0x1b3
    assign w_mix   = r_hash ^ {{(hrdl_pkg::HASH_W-8){1'b0}}, r_id[7:0]};
    assign w_prod  = w_mix * {{(hrdl_pkg::HASH_W-9){1'b0}}, hrdl_pkg::FNV_PRIME_LO};
    assign w_round = w_prod + (w_mix << hrdl_pkg::FNV_PRIME_SHIFT);

    // item capture and hash rounds
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_op      <= i_opcode;
            r_slot    <= i_slot;
            r_pt_hash <= i_point_hash;
            r_pt_disk <= w_disk_clamp;
            r_id      <= i_object_id;
            r_hash    <= hrdl_pkg::FNV_BASIS;
            r_byte    <= '0;
        end else if (i_ctrl.hash) begin
            r_hash <= w_round;
            r_id   <= r_id >> 8;
            r_byte <= r_byte + 1'b1;
        end
    end

    // search bounds
    always_ff @(posedge i_clk) begin
        if (i_ctrl.setup) begin
            r_lo <= '0;
            r_hi <= w_last;
        end else if (i_ctrl.wrap) begin
            r_hi <= '0;
        end else if (i_ctrl.upd) begin
            if (r_q_hash < r_hash) begin
                r_lo <= w_mid;
            end else begin
                r_hi <= w_mid;
            end
        end
    end

    // point count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_points <= hrdl_pkg::CNT_W'(1);
        end else if (i_cfg_we) begin
            r_points <= i_cfg_wdata;
        end
    end

    // result strobe and payload
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_ctrl.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.emit) begin
            r_disk  <= r_q_disk;
            r_found <= hrdl_pkg::SLOT_W'(r_hi);
        end
    end

    // status for the sequencer
    assign o_stat.lookup    = (r_op == hrdl_pkg::OP_LOOKUP);
    assign o_stat.hash_more = (r_byte != hrdl_pkg::BYTE_IDX_W'(hrdl_pkg::BYTES - 1));
    assign o_stat.above     = (r_hash > r_q_hash);
    assign o_stat.atmost    = (r_hash <= r_q_hash);
    assign o_stat.span_done = (w_span <= AW'(1));

    assign o_done       = r_done;
    assign o_disk_index = r_disk;
    assign o_found_slot = r_found;

    // checks
    a_search_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.upd |-> (r_lo < r_hi))
        else $error("search bounds crossed");

    a_result_in_ring: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.emit |-> (r_hi <= w_last))
        else $error("selected slot beyond active points");

endmodule
`default_nettype wire

>>> bench/hrdl_ring_checker.sv
// ============================================================================
// hrdl_ring_checker : placement predictor and result checker for the ring
// Keeps its own copy of the ring table and point count, built from accepted
// load items and register writes, works out the disk and slot that every
// accepted lookup should return, and compares each o_done strobe with the
// oldest placement still outstanding.
// ============================================================================
package hrdl_tb_pkg;

    // 64-bit fnv-1a multiplier
    localparam logic [63:0] FNV_MULT = 64'h0000_0100_0000_01b3;

    // fnv-1a over the eight bytes of an object id, low byte first
    function automatic logic [63:0] object_hash(input logic [63:0] id);
        logic [63:0] h;
        h = hrdl_pkg::FNV_BASIS;
        for (int b = 0; b < 8; b++) begin
            h = h ^ {56'd0, id[8*b +: 8]};
            h = h * FNV_MULT;
        end
        return h;
    endfunction

endpackage

module hrdl_ring_checker
    import hrdl_pkg::*;
    import hrdl_tb_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF,
    parameter int MAX_DISKS  = MAX_DISKS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic              i_busy,
    input  wire logic              i_opcode,
    input  wire logic [SLOT_W-1:0] i_slot,
    input  wire logic [HASH_W-1:0] i_point_hash,
    input  wire logic [DISK_W-1:0] i_point_disk,
    input  wire logic [ID_W-1:0]   i_object_id,
    input  wire logic              i_cfg_we,
    input  wire logic [CNT_W-1:0]  i_cfg_wdata,
    input  wire logic              i_done,
    input  wire logic [DISK_W-1:0] i_disk_index,
    input  wire logic [SLOT_W-1:0] i_found_slot,
    output int                     o_fail_count,
    output int                     o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [DISK_W-1:0] disk;
        logic [SLOT_W-1:0] slot;
    } t_placement;

    // shadow ring and point count
    logic [HASH_W-1:0] ring_hash [MAX_POINTS];
    logic [DISK_W-1:0] ring_disk [MAX_POINTS];
    logic [CNT_W-1:0]  ring_count;

    t_placement placements_due [$];
    int         mismatches = 0;

    // binary search for the first point at or above the object hash
    function automatic t_placement ring_owner(input logic [ID_W-1:0] id);
        logic [HASH_W-1:0] h;
        int unsigned       n, lo, hi, mid;
        t_placement        p;
        h = object_hash(id);
        n = 32'(ring_count);
        if (n == 0) n = 1;
        if (n > 32'(MAX_POINTS)) n = 32'(MAX_POINTS);
        lo = 0;
        hi = n - 1;
        if (h > ring_hash[hi] || h <= ring_hash[0]) begin
            // wraps to the first slot, also on a hit of the lowest point
            hi = 0;
        end else begin
            while (hi - lo > 1) begin
                mid = lo + (hi - lo) / 2;
                if (ring_hash[mid] < h) lo = mid;
                else hi = mid;
            end
        end
        p.slot = SLOT_W'(hi);
        p.disk = ring_disk[hi];
        return p;
    endfunction

    // compare results, then track register writes and accepted items
    always @(posedge i_clk) begin
        t_placement want;
        if (!i_rst_n) begin
            ring_count = CNT_W'(1);
            placements_due.delete();
        end else begin
            if (i_done !== 1'b0) begin
                if (placements_due.size() == 0) begin
                    if (mismatches < 10)
                        $display("%0t: unexpected lookup result: disk %0d slot %0d",
                                 $realtime, i_disk_index, i_found_slot);
                    mismatches++;
                end else begin
                    want = placements_due.pop_front();
                    if (want.disk !== i_disk_index || want.slot !== i_found_slot) begin
                        if (mismatches < 10)
                            $display({"%0t: lookup mismatch: expected disk %0d slot %0d,",
                                      " got disk %0d slot %0d"},
                                     $realtime, want.disk, want.slot,
                                     i_disk_index, i_found_slot);
                        mismatches++;
                    end
                end
            end
            if (i_cfg_we) ring_count = i_cfg_wdata;
            if (i_start && !i_busy) begin
                if (i_opcode == OP_LOAD) begin
                    if (32'(i_slot) < 32'(MAX_POINTS)) begin
                        ring_hash[i_slot] = i_point_hash;
                        ring_disk[i_slot] = (32'(i_point_disk) >= 32'(MAX_DISKS))
                                          ? DISK_W'(MAX_DISKS - 1) : i_point_disk;
                    end
                end else begin
                    placements_due.push_back(ring_owner(i_object_id));
                end
            end
        end
        o_pending    <= placements_due.size();
        o_fail_count <= mismatches;
    end

endmodule

>>> bench/tb_hash_ring_disk_lookup.sv
// ============================================================================
// tb_hash_ring_disk_lookup : stimulus and verdict for the hash ring lookup
// Loads sorted ring tables of several sizes, some with points planted on the
// hashes of known object ids, and fires lookups at them with random sender
// gaps. Prediction and comparison live in the ring checker beside the block.
// ============================================================================
module tb_hash_ring_disk_lookup;
    timeunit 1ns;
    timeprecision 1ps;

    import hrdl_pkg::*;
    import hrdl_tb_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 4;
    localparam int DRAIN_CYCLES   = 60;

    logic              i_clk        = 1'b0;
    logic              i_rst_n      = 1'b0;
    logic              start        = 1'b0;
    logic              busy;
    logic              i_opcode     = OP_LOAD;
    logic [SLOT_W-1:0] i_slot       = '0;
    logic [HASH_W-1:0] i_point_hash = '0;
    logic [DISK_W-1:0] i_point_disk = '0;
    logic [ID_W-1:0]   i_object_id  = '0;
    logic              i_cfg_we     = 1'b0;
    logic [CNT_W-1:0]  i_cfg_wdata  = '0;
    logic              o_done;
    logic [DISK_W-1:0] o_disk_index;
    logic [SLOT_W-1:0] o_found_slot;

    int fail_count;
    int pending;
    int quiet_cycles = 0;
    int idle_pct     = 28;

    // planned ring contents and ids whose hash sits exactly on a point
    logic [HASH_W-1:0] ring_plan [MAX_POINTS_DEF];
    logic [ID_W-1:0]   match_ids [$];

    hash_ring_disk_lookup dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_opcode     (i_opcode),
        .i_slot       (i_slot),
        .i_point_hash (i_point_hash),
        .i_point_disk (i_point_disk),
        .i_object_id  (i_object_id),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_done       (o_done),
        .o_disk_index (o_disk_index),
        .o_found_slot (o_found_slot)
    );

    hrdl_ring_checker u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_opcode     (i_opcode),
        .i_slot       (i_slot),
        .i_point_hash (i_point_hash),
        .i_point_disk (i_point_disk),
        .i_object_id  (i_object_id),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_done       (o_done),
        .i_disk_index (o_disk_index),
        .i_found_slot (o_found_slot),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // watchdog on cycles with nothing accepted and no result
    always @(posedge i_clk) begin
        if ((start && !busy) || o_done) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // random id whose hash lies strictly between two bounds
    function automatic logic [ID_W-1:0] id_hashing_between(input logic [HASH_W-1:0] lo,
                                                           input logic [HASH_W-1:0] hi);
        logic [ID_W-1:0]   id;
        logic [HASH_W-1:0] h;
        id = rand64();
        h  = object_hash(id);
        for (int k = 0; k < 100000 && !(h > lo && h < hi); k++) begin
            id = rand64();
            h  = object_hash(id);
        end
        return id;
    endfunction

    // present one item, with a random gap first, and hold it until taken
    task automatic issue(input logic op, input logic [SLOT_W-1:0] slot,
                         input logic [HASH_W-1:0] hash, input logic [DISK_W-1:0] disk,
                         input logic [ID_W-1:0] id);
        if (idle_pct != 0 && $urandom_range(1) == 1) begin
            do begin
                start <= 1'b0;
                @(posedge i_clk);
            end while (busy);
        end
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start        <= 1'b1;
        i_opcode     <= op;
        i_slot       <= slot;
        i_point_hash <= hash;
        i_point_disk <= disk;
        i_object_id  <= id;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic load_point(input logic [SLOT_W-1:0] slot, input logic [HASH_W-1:0] hash,
                              input logic [DISK_W-1:0] disk);
        issue(OP_LOAD, slot, hash, disk, rand64());
    endtask

    task automatic lookup(input logic [ID_W-1:0] id);
        issue(OP_LOOKUP, SLOT_W'($urandom_range(MAX_POINTS_DEF - 1)), rand64(),
              DISK_W'($urandom_range(15)), id);
    endtask

    // stop sending and wait until the block is idle with nothing outstanding
    task automatic drain();
        do begin
            start <= 1'b0;
            @(posedge i_clk);
        end while (pending != 0 || busy);
    endtask

    task automatic write_count(input logic [CNT_W-1:0] value);
        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // sorted table spread over the whole hash range, one point per bucket,
    // some points moved onto the hash of a known id, a few doubled up
    task automatic build_ring(input int unsigned n);
        logic [HASH_W-1:0] bucket;
        logic [HASH_W-1:0] h;
        logic [ID_W-1:0]   id;
        int unsigned       s;
        match_ids.delete();
        bucket = 64'hffff_ffff_ffff_ffff / 64'(n);
        for (int i = 0; i < n; i++)
            ring_plan[i] = 64'(i) * bucket + rand64() % bucket;
        for (int k = 0; k < 1 + n / 16; k++) begin
            id = rand64();
            h  = object_hash(id);
            s  = 32'(h / bucket);
            if (s >= n) s = n - 1;
            ring_plan[s] = h;
            if (s + 1 < n && $urandom_range(1) == 1) ring_plan[s + 1] = h;
            match_ids.push_back(id);
        end
        for (int i = 0; i < n; i++)
            load_point(SLOT_W'(i), ring_plan[i], DISK_W'($urandom_range(15)));
    endtask

    // four points on the hashes of fixed ids, then the wrap and order cases
    task automatic run_directed();
        logic [ID_W-1:0]   ids [4];
        logic [HASH_W-1:0] hs [4];
        logic [HASH_W-1:0] t;
        ids[0] = 64'd0;
        ids[1] = 64'hffff_ffff_ffff_ffff;
        ids[2] = 64'h0123_4567_89ab_cdef;
        ids[3] = 64'h8000_0000_0000_0000;
        for (int a = 0; a < 4; a++) hs[a] = object_hash(ids[a]);
        for (int a = 1; a < 4; a++) begin
            for (int b = a; b > 0; b--) begin
                if (hs[b - 1] > hs[b]) begin
                    t = hs[b];  hs[b]  = hs[b - 1];  hs[b - 1]  = t;
                    t = ids[b]; ids[b] = ids[b - 1]; ids[b - 1] = t;
                end
            end
        end
        write_count(12'd4);
        for (int a = 0; a < 4; a++) load_point(SLOT_W'(a), hs[a], DISK_W'(a * 5));
        // exact hits, the lowest point included
        for (int a = 0; a < 4; a++) lookup(ids[a]);
        // below the first point, between two points, above the last
        lookup(id_hashing_between(64'd0, hs[0]));
        lookup(id_hashing_between(hs[1], hs[2]));
        lookup(id_hashing_between(hs[3], 64'hffff_ffff_ffff_ffff));
        // disordered table: last point at zero, then first point at all ones
        load_point(SLOT_W'(3), 64'd0, 4'd7);
        lookup(rand64());
        lookup(rand64());
        load_point(SLOT_W'(0), 64'hffff_ffff_ffff_ffff, 4'd15);
        lookup(rand64());
    endtask

    // one point count: mostly lookups, some loads off the searched range,
    // a few loads that break the order
    task automatic run_phase(input logic [CNT_W-1:0] count, input int unsigned used,
                             input bit rebuild, input int unsigned lookups, input int pct);
        int unsigned     sent;
        int unsigned     r;
        logic [ID_W-1:0] id;
        idle_pct = pct;
        write_count(count);
        if (rebuild) build_ring(used);
        sent = 0;
        while (sent < lookups) begin
            r = $urandom_range(99);
            if (r < 6 && used < MAX_POINTS_DEF) begin
                load_point(SLOT_W'($urandom_range(MAX_POINTS_DEF - 1, used)), rand64(),
                           DISK_W'($urandom_range(15)));
            end else if (r < 8) begin
                load_point(SLOT_W'($urandom_range(used - 1)), rand64(),
                           DISK_W'($urandom_range(15)));
            end else begin
                r = $urandom_range(99);
                if (r < 20 && match_ids.size() != 0)
                    id = match_ids[$urandom_range(match_ids.size() - 1)];
                else if (r < 25)
                    id = ($urandom_range(1) == 1) ? 64'hffff_ffff_ffff_ffff : 64'd0;
                else
                    id = rand64();
                lookup(id);
                sent++;
            end
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        idle_pct = 28;
        run_directed();
        // largest table once; the next count reuses it
        run_phase(12'd256,   256, 1'b1, 100, 28);
        run_phase(12'd255,   255, 1'b0,  60, 28);
        run_phase(12'd1,       1, 1'b1,  30, 28);
        run_phase(12'd0,       1, 1'b1,  30, 87);
        run_phase(12'd2,       2, 1'b1,  50, 87);
        run_phase(12'd3,       3, 1'b1,  50, 87);
        run_phase(12'd5,       5, 1'b1,  60, 87);
        run_phase(12'd16,     16, 1'b1,  80, 0);
        run_phase(12'd64,     64, 1'b1,  80, 0);
        run_phase(12'd100,   100, 1'b1,  80, 0);
        drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
